@@ rtl/core/itda_pkg.sv @@
`default_nettype none
package itda_pkg;

  // Operand and text sizes
  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 6;
  localparam int BCNT_W     = $clog2(VALUE_W);
  localparam int DCNT_W     = $clog2(NUM_DIGITS);

  // Character codes
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 6'd45;

  // Double-dabble correction: a digit of five or more gets three added
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  // Mode codes
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // Last iteration / digit positions
  localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(VALUE_W - 1);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_DIGITS - 1);

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture magnitude and sign, clear counters
    logic shift_bit;    // one double-dabble step
    logic shift_digit;  // drop the top BCD digit
    logic sel_sign;     // output shows the minus sign
  } itda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic negative;     // value printed with a leading minus
    logic bit_last;     // final conversion step in progress
    logic digit_zero;   // top BCD digit is zero
    logic digit_last;   // top BCD digit is the units digit
  } itda_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/itda_dp.sv @@
`default_nettype none
module itda_dp import itda_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               opcode,
  input  wire itda_cmd_t          cmd,
  output itda_sts_t               sts,
  output logic      [CHAR_W-1:0]  character,
  output logic                    last
);

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic [BCNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic               neg_in;
  logic [DIGIT_W-1:0] top_digit;

  // Sign detect on the incoming operand
  assign neg_in = (opcode == OP_SIGNED) && value[VALUE_W-1];

  // Add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Next-value selection
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    bcnt_nxt = bcnt_r;
    dcnt_nxt = dcnt_r;
    if (cmd.load) begin
      bin_nxt  = neg_in ? (VALUE_W'(0) - value) : value;
      bcd_nxt  = '0;
      neg_nxt  = neg_in;
      bcnt_nxt = '0;
      dcnt_nxt = '0;
    end else if (cmd.shift_bit) begin
      bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
      bcnt_nxt = bcnt_r + 1'b1;
    end else if (cmd.shift_digit) begin
      bcd_nxt  = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      dcnt_nxt = dcnt_r + 1'b1;
    end
  end

  // Counters and sign flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      dcnt_r <= '0;
      neg_r  <= 1'b0;
    end else begin
      bcnt_r <= bcnt_nxt;
      dcnt_r <= dcnt_nxt;
      neg_r  <= neg_nxt;
    end
  end

  // Shift registers, payload only
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  assign sts.negative   = neg_r;
  assign sts.bit_last   = (bcnt_r == BCNT_LAST);
  assign sts.digit_zero = (top_digit == '0);
  assign sts.digit_last = (dcnt_r == DCNT_LAST);

  // Character out
  assign character = cmd.sel_sign ? MINUS_CHAR
                                  : (DIGIT_BASE + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit});
  assign last      = !cmd.sel_sign && (dcnt_r == DCNT_LAST);

endmodule
`default_nettype wire

@@ rtl/core/itda_ctrl.sv @@
`default_nettype none
module itda_ctrl import itda_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire itda_sts_t sts,
  output itda_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.sel_sign    = (state_r == S_SIGN);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift_bit = 1'b1;
        if (sts.bit_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // skip leading zeros, keep the units digit
        if (sts.digit_zero && !sts.digit_last) begin
          cmd.shift_digit = 1'b1;
        end else if (sts.negative) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_ready) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_ready) begin
          if (sts.digit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.shift_digit = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt  = (state_nxt == S_IDLE);
    out_valid_nxt = (state_nxt == S_SIGN) || (state_nxt == S_DIGIT);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/core/integer_to_decimal_ascii.sv @@
// Sequence: after the input transfer the BCD shifter converts one bit per cycle, then
//   the scan skips leading zero digits, then the first character is presented.
// Input: a new value is taken only after the previous text is sent; the emitter gives
//   one digit per cycle while out_tready is high, and out_tready low stalls it.
// Reset: synchronous, active low; the block comes up idle with no output pending.
`default_nettype none
module integer_to_decimal_ascii import itda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  input  wire logic [0:0]  in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [5:0] character, [7:6] zero
  output logic             out_tlast   // last
);

  itda_cmd_t         cmd;
  itda_sts_t         sts;
  logic [CHAR_W-1:0] character;

  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itda_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .value     (in_tdata[VALUE_W-1:0]),
    .opcode    (in_tuser[0]),
    .cmd       (cmd),
    .sts       (sts),
    .character (character),
    .last      (out_tlast)
  );

  assign out_tdata = {{(8-CHAR_W){1'b0}}, character};

endmodule
`default_nettype wire

@@ rtl/core/itda_chk.sv @@
`default_nettype none
module itda_chk import itda_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // No new input while characters of the previous one are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output pending");

  // Conversion takes time: nothing shows right after an input transfer
  a_conv_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("output too soon after input transfer");

  // Only the minus sign or a digit is sent, and a sign never ends the text
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] == 2'b00) &&
      ((out_tdata[5:0] == MINUS_CHAR && !out_tlast) ||
       (out_tdata[5:0] >= DIGIT_BASE && out_tdata[5:0] <= DIGIT_BASE + 6'd9)))
    else $error("illegal output character");

endmodule

bind integer_to_decimal_ascii itda_chk u_itda_chk (.*);
`default_nettype wire
